// ===== rtl/core/jddm_pkg.sv =====
// Shared types, constants and the divider step of the joystick drive mixer.
package jddm_pkg;

   // Field widths.
   localparam int AXIS_W  = 10;
   localparam int DUTY_W  = 8;
   localparam int TRIM_W  = 9;
   localparam int CSR_W   = 9;

   // Dead zone used when the register holds zero.
   localparam logic [8:0] DEFAULT_DEAD_ZONE = 9'd16;

   // Register reset values.
   localparam logic [7:0] RST_PWM_MAX      = 8'd220;
   localparam logic [8:0] RST_DEAD_ZONE    = 9'd10;
   localparam logic [7:0] RST_TURN_GAIN    = 8'd16;
   localparam logic [7:0] RST_SPEED_FACTOR = 8'd128;

   // Turbo steering limit: 100 in the Q13 scale of the steering product.
   localparam logic signed [23:0] TURN_LIMIT = 24'sd819200;

   // Register indexes of the configuration port.
   typedef enum logic [2:0] {
      CSR_PWM_MAX      = 3'd0,
      CSR_TRIM_LEFT    = 3'd1,
      CSR_TRIM_RIGHT   = 3'd2,
      CSR_AXIS_INVERT  = 3'd3,
      CSR_DEAD_ZONE    = 3'd4,
      CSR_TURN_GAIN    = 3'd5,
      CSR_TURN_STICK   = 3'd6,
      CSR_SPEED_FACTOR = 3'd7
   } csr_index_type;

   // One axis in flight through the restoring divider.
   typedef struct packed {
      logic       neg;   // axis was negative
      logic [8:0] rem;   // partial remainder, always below the divisor
      logic [9:0] nlo;   // dividend bits still to bring down, MSB first
      logic [9:0] quo;   // quotient bits so far
   } div_lane_type;

   // One restoring division step: bring down a bit, subtract if it fits.
   function automatic div_lane_type div_step(input div_lane_type cur,
                                             input logic [8:0] divisor);
      logic [9:0]   trial;
      div_lane_type nxt;
      nxt     = cur;
      trial   = {cur.rem, cur.nlo[9]};
      nxt.nlo = {cur.nlo[8:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
         nxt.rem = 9'(trial - {1'b0, divisor});
         nxt.quo = {cur.quo[8:0], 1'b1};
      end else begin
         nxt.rem = trial[8:0];
         nxt.quo = {cur.quo[8:0], 1'b0};
      end
      return nxt;
   endfunction

endpackage

// ===== rtl/core/joystick_differential_drive_mixer.sv =====
// Top level of the joystick differential drive mixer: an eight-stage pipeline.
//
// One joystick sample is taken in every clock cycle (start high; busy stays low), and
// its four PWM duties appear on the rsp_ ports, marked by a single cycle of
// rsp_strobe. There is no back-pressure: every beat on rsp_ must be taken in
// the cycle it is shown. The dead-zone rescale, a ten-bit restoring divider spread
// over three stages, is followed by the mixing multipliers and the saturation logic.
// Configuration registers, written through csr_, take a write at the next clock edge;
// the user must write only while no sample is in flight; the block does not check.
module joystick_differential_drive_mixer (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic                             req_mode,
   input  logic signed [jddm_pkg::AXIS_W-1:0] req_left_x,
   input  logic signed [jddm_pkg::AXIS_W-1:0] req_right_x,
   input  logic signed [jddm_pkg::AXIS_W-1:0] req_right_y,
   output logic                             rsp_strobe,
   output logic [jddm_pkg::DUTY_W-1:0]      rsp_left_forward,
   output logic [jddm_pkg::DUTY_W-1:0]      rsp_left_reverse,
   output logic [jddm_pkg::DUTY_W-1:0]      rsp_right_forward,
   output logic [jddm_pkg::DUTY_W-1:0]      rsp_right_reverse,
   input  logic                             csr_write_en,
   input  logic [2:0]                       csr_index,
   input  logic [jddm_pkg::CSR_W-1:0]       csr_wdata
);
   import jddm_pkg::*;

   localparam int LANE_T = 0;   // turn axis
   localparam int LANE_F = 1;   // forward axis
   localparam int SIDE_L = 0;
   localparam int SIDE_R = 1;

   // Configuration registers.
   logic [7:0]               pwm_max_ff;
   logic signed [TRIM_W-1:0] trim_left_ff;
   logic signed [TRIM_W-1:0] trim_right_ff;
   logic [1:0]               axis_invert_ff;
   logic [8:0]               dead_zone_ff;
   logic [7:0]               turn_gain_ff;
   logic                     turn_stick_ff;
   logic [7:0]               speed_factor_ff;

   // Values derived from the configuration.
   logic [8:0]  zone;
   logic [8:0]  divisor;
   logic [14:0] speed_k;

   // Pipeline valid bits, one per stage.
   logic [7:0] vld_ff;
   logic       accept;

   // Stage registers.
   logic                mode_ff   [1:5];
   div_lane_type        div1_ff   [2];
   div_lane_type        div1_in   [2];
   div_lane_type        div2_ff   [2];
   div_lane_type        div2_in   [2];
   div_lane_type        div3_ff   [2];
   div_lane_type        div3_in   [2];
   div_lane_type        div4_ff   [2];
   div_lane_type        div4_in   [2];
   logic signed [11:0]  sum5_ff,  sum5_in;
   logic signed [11:0]  dif5_ff,  dif5_in;
   logic signed [18:0]  tprod5_ff, tprod5_in;
   logic                idle5_ff, idle5_in;
   logic signed [26:0]  mix6_ff   [2];
   logic signed [26:0]  mix6_in   [2];
   logic signed [23:0]  tnum6_ff, tnum6_in;
   logic                mode6_ff;
   logic                idle6_ff;
   logic [7:0]          duty7_ff  [2];
   logic [7:0]          duty7_in  [2];
   logic                rev7_ff   [2];
   logic                rev7_in   [2];
   logic                idle7_ff;
   logic [7:0]          lf_in, lr_in, rf_in, rr_in;
   logic [7:0]          lf_ff, lr_ff, rf_ff, rr_ff;

   assign busy   = 1'b0;
   assign accept = start & ~busy;

   // Effective dead zone, divisor of the rescale and normal-mode gain.
   assign zone    = (dead_zone_ff == 9'd0) ? DEFAULT_DEAD_ZONE : dead_zone_ff;
   assign divisor = 9'(10'd512 - {1'b0, zone});
   assign speed_k = 15'({speed_factor_ff, 7'd0} - {7'd0, speed_factor_ff});

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         pwm_max_ff      <= RST_PWM_MAX;
         trim_left_ff    <= '0;
         trim_right_ff   <= '0;
         axis_invert_ff  <= '0;
         dead_zone_ff    <= RST_DEAD_ZONE;
         turn_gain_ff    <= RST_TURN_GAIN;
         turn_stick_ff   <= 1'b0;
         speed_factor_ff <= RST_SPEED_FACTOR;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_PWM_MAX:      pwm_max_ff      <= csr_wdata[7:0];
            CSR_TRIM_LEFT:    trim_left_ff    <= signed'(csr_wdata);
            CSR_TRIM_RIGHT:   trim_right_ff   <= signed'(csr_wdata);
            CSR_AXIS_INVERT:  axis_invert_ff  <= csr_wdata[1:0];
            CSR_DEAD_ZONE:    dead_zone_ff    <= csr_wdata;
            CSR_TURN_GAIN:    turn_gain_ff    <= csr_wdata[7:0];
            CSR_TURN_STICK:   turn_stick_ff   <= csr_wdata[0];
            CSR_SPEED_FACTOR: speed_factor_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // Stage 1: pick and invert the axes, take magnitudes, remove the dead zone.
   always_comb begin
      logic signed [10:0] src;
      logic signed [10:0] val [2];
      logic [10:0]        mag;
      logic [8:0]         diff;
      src = req_mode ? (turn_stick_ff ? {req_right_x[9], req_right_x}
                                      : {req_left_x[9], req_left_x})
                     : {req_right_x[9], req_right_x};
      val[LANE_T] = axis_invert_ff[0] ? -src : src;
      val[LANE_F] = axis_invert_ff[1] ? {req_right_y[9], req_right_y}
                                      : -{req_right_y[9], req_right_y};
      for (int l = 0; l < 2; l++) begin
         mag  = val[l][10] ? 11'(-val[l]) : 11'(val[l]);
         diff = (mag >= {2'b0, zone}) ? 9'(mag - {2'b0, zone}) : 9'd0;
         div1_in[l].neg = val[l][10];
         div1_in[l].rem = {1'b0, diff[8:1]};
         div1_in[l].nlo = {diff[0], 9'd0};
         div1_in[l].quo = '0;
      end
   end

   // Stages 2 to 4: restoring division, four, three and three steps.
   always_comb begin
      for (int l = 0; l < 2; l++) begin
         div2_in[l] = div1_ff[l];
         for (int s = 0; s < 4; s++) begin
            div2_in[l] = div_step(div2_in[l], divisor);
         end
         div3_in[l] = div2_ff[l];
         for (int s = 0; s < 3; s++) begin
            div3_in[l] = div_step(div3_in[l], divisor);
         end
         div4_in[l] = div3_ff[l];
         for (int s = 0; s < 3; s++) begin
            div4_in[l] = div_step(div4_in[l], divisor);
         end
      end
   end

   // Stage 5: restore signs, form the mix terms and the steering product.
   always_comb begin
      logic signed [10:0] raw [2];
      logic signed [18:0] raw_ext;
      for (int l = 0; l < 2; l++) begin
         raw[l] = div4_ff[l].neg ? -signed'({1'b0, div4_ff[l].quo})
                                 :  signed'({1'b0, div4_ff[l].quo});
      end
      sum5_in   = {raw[LANE_F][10], raw[LANE_F]} + {raw[LANE_T][10], raw[LANE_T]};
      dif5_in   = {raw[LANE_F][10], raw[LANE_F]} - {raw[LANE_T][10], raw[LANE_T]};
      raw_ext   = 19'(raw[LANE_T]);
      tprod5_in = raw_ext * signed'({11'd0, turn_gain_ff});
      idle5_in  = ~mode_ff[4] & (div4_ff[LANE_T].quo == '0) & (div4_ff[LANE_F].quo == '0);
   end

   // Stage 6: normal-mode scaling and the turbo steering term times twenty.
   always_comb begin
      logic signed [26:0] k_ext;
      logic signed [23:0] tp_ext;
      k_ext          = signed'({12'd0, speed_k});
      mix6_in[SIDE_L] = 27'(sum5_ff) * k_ext;
      mix6_in[SIDE_R] = 27'(dif5_ff) * k_ext;
      tp_ext         = 24'(tprod5_ff);
      tnum6_in       = (tp_ext <<< 4) + (tp_ext <<< 2);
   end

   // Stage 7: duty magnitude and direction per side, before trim.
   always_comb begin
      logic signed [23:0] ns;
      logic signed [23:0] nn;
      logic signed [10:0] tside [2];
      logic [26:0]        mag;
      logic [10:0]        dq;
      mag = '0;
      dq  = '0;
      ns = (tnum6_ff > TURN_LIMIT) ? TURN_LIMIT
         : ((tnum6_ff < -TURN_LIMIT) ? -TURN_LIMIT : tnum6_ff);
      nn = -ns;
      tside[SIDE_L] = signed'({3'd0, pwm_max_ff}) + ns[23:13];
      tside[SIDE_R] = signed'({3'd0, pwm_max_ff}) + nn[23:13];
      for (int s = 0; s < 2; s++) begin
         if (mode6_ff) begin
            rev7_in[s] = 1'b0;
            if (tside[s] < 0) begin
               duty7_in[s] = 8'd0;
            end else if (tside[s] > 11'sd255) begin
               duty7_in[s] = 8'd255;
            end else begin
               duty7_in[s] = tside[s][7:0];
            end
         end else begin
            rev7_in[s]  = mix6_ff[s][26];
            mag         = mix6_ff[s][26] ? 27'(-mix6_ff[s]) : 27'(mix6_ff[s]);
            dq          = mag[26:16];
            duty7_in[s] = (dq > {3'd0, pwm_max_ff}) ? pwm_max_ff : dq[7:0];
         end
      end
   end

   // Stage 8: add trim, saturate, route to forward or reverse; all zero when idle.
   always_comb begin
      logic signed [10:0] acc [2];
      logic [7:0]         v   [2];
      acc[SIDE_L] = signed'({3'd0, duty7_ff[SIDE_L]}) + 11'(trim_left_ff);
      acc[SIDE_R] = signed'({3'd0, duty7_ff[SIDE_R]}) + 11'(trim_right_ff);
      for (int s = 0; s < 2; s++) begin
         if (acc[s] < 0) begin
            v[s] = 8'd0;
         end else if (acc[s] > 11'sd255) begin
            v[s] = 8'd255;
         end else begin
            v[s] = acc[s][7:0];
         end
      end
      if (idle7_ff) begin
         lf_in = 8'd0;
         lr_in = 8'd0;
         rf_in = 8'd0;
         rr_in = 8'd0;
      end else begin
         lf_in = rev7_ff[SIDE_L] ? 8'd0 : v[SIDE_L];
         lr_in = rev7_ff[SIDE_L] ? v[SIDE_L] : 8'd0;
         rf_in = rev7_ff[SIDE_R] ? 8'd0 : v[SIDE_R];
         rr_in = rev7_ff[SIDE_R] ? v[SIDE_R] : 8'd0;
      end
   end

   // Valid bits travel with each sample.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[6:0], accept};
      end
   end

   // Pipeline data registers.
   always_ff @(posedge clock) begin
      mode_ff[1] <= req_mode;
      for (int i = 2; i <= 5; i++) begin
         mode_ff[i] <= mode_ff[i-1];
      end
      div1_ff   <= div1_in;
      div2_ff   <= div2_in;
      div3_ff   <= div3_in;
      div4_ff   <= div4_in;
      sum5_ff   <= sum5_in;
      dif5_ff   <= dif5_in;
      tprod5_ff <= tprod5_in;
      idle5_ff  <= idle5_in;
      mix6_ff   <= mix6_in;
      tnum6_ff  <= tnum6_in;
      mode6_ff  <= mode_ff[5];
      idle6_ff  <= idle5_ff;
      duty7_ff  <= duty7_in;
      rev7_ff   <= rev7_in;
      idle7_ff  <= idle6_ff;
      lf_ff     <= lf_in;
      lr_ff     <= lr_in;
      rf_ff     <= rf_in;
      rr_ff     <= rr_in;
   end

   // Result beat.
   assign rsp_strobe        = vld_ff[7];
   assign rsp_left_forward  = lf_ff;
   assign rsp_left_reverse  = lr_ff;
   assign rsp_right_forward = rf_ff;
   assign rsp_right_reverse = rr_ff;

endmodule

// ===== sim/tb_joystick_differential_drive_mixer.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of the joystick differential drive mixer, with its own predictor.
module tb_joystick_differential_drive_mixer;
   import jddm_pkg::*;

   localparam logic MODE_NORMAL = 1'b0;
   localparam logic MODE_TURBO  = 1'b1;
   localparam int   Q13         = 8192;
   localparam int   STEER_LIMIT = 100 * Q13;
   localparam int   DRAIN_CYCLES = 16;
   localparam int   ITEMS_PER_BLOCK = 104;
   localparam int   DIRECTED_ROWS = 13;
   localparam int   MAX_REPORTS = 10;

   typedef struct packed {
      logic                     mode;
      logic signed [AXIS_W-1:0] left_x;
      logic signed [AXIS_W-1:0] right_x;
      logic signed [AXIS_W-1:0] right_y;
   } stick_sample_type;

   typedef struct packed {
      logic [DUTY_W-1:0] left_forward;
      logic [DUTY_W-1:0] left_reverse;
      logic [DUTY_W-1:0] right_forward;
      logic [DUTY_W-1:0] right_reverse;
   } duty_set_type;

   typedef struct packed {
      stick_sample_type sample;
      logic             known;
      duty_set_type     duties;
   } directed_row_type;

   typedef struct {
      logic [7:0]        pwm_max;
      logic signed [8:0] trim_left;
      logic signed [8:0] trim_right;
      logic [1:0]        axis_invert;
      logic [8:0]        dead_zone;
      logic [7:0]        turn_gain;
      logic              turn_stick;
      logic [7:0]        speed_factor;
   } mixer_cfg_type;

   logic                     clock;
   logic                     reset;
   logic                     start;
   logic                     busy;
   logic                     req_mode;
   logic signed [AXIS_W-1:0] req_left_x;
   logic signed [AXIS_W-1:0] req_right_x;
   logic signed [AXIS_W-1:0] req_right_y;
   logic                     rsp_strobe;
   logic [DUTY_W-1:0]        rsp_left_forward;
   logic [DUTY_W-1:0]        rsp_left_reverse;
   logic [DUTY_W-1:0]        rsp_right_forward;
   logic [DUTY_W-1:0]        rsp_right_reverse;
   logic                     csr_write_en;
   logic [2:0]               csr_index;
   logic [CSR_W-1:0]         csr_wdata;

   mixer_cfg_type mixer_cfg;
   duty_set_type  pending_duties[$];
   int            mismatch_count;
   int            sender_gap_pct;

   joystick_differential_drive_mixer i_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_mode          (req_mode),
      .req_left_x        (req_left_x),
      .req_right_x       (req_right_x),
      .req_right_y       (req_right_y),
      .rsp_strobe        (rsp_strobe),
      .rsp_left_forward  (rsp_left_forward),
      .rsp_left_reverse  (rsp_left_reverse),
      .rsp_right_forward (rsp_right_forward),
      .rsp_right_reverse (rsp_right_reverse),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Overall time limit.
   initial begin
      #400_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   function automatic int clamp(int v, int lo, int hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   // Dead zone with integer rescale back to the full 0..512 span.
   function automatic int apply_dead_zone(int v, int z);
      int mag;
      int scaled;
      mag = (v < 0) ? -v : v;
      if (mag < z) return 0;
      scaled = (mag - z) * 512 / (512 - z);
      return (v < 0) ? -scaled : scaled;
   endfunction

   // One side of the normal mix: magnitude limited to pwm_max, trimmed, split by sign.
   function automatic void drive_side(input int mix, input int trim,
                                      output logic [7:0] fwd, output logic [7:0] rev);
      int mag;
      int duty;
      mag  = ((mix < 0) ? -mix : mix) / 65536;
      mag  = clamp(mag, 0, int'(mixer_cfg.pwm_max));
      duty = clamp(mag + trim, 0, 255);
      fwd  = (mix >= 0) ? 8'(duty) : 8'd0;
      rev  = (mix >= 0) ? 8'd0 : 8'(duty);
   endfunction

   // Four PWM duties for one joystick sample under the current register settings.
   function automatic duty_set_type mix_duties(stick_sample_type s);
      int           z;
      int           ax;
      int           steer;
      int           base;
      int           x;
      int           y;
      int           fw;
      int           tn;
      int           k;
      duty_set_type d;
      d = '0;
      z = (mixer_cfg.dead_zone != 0) ? int'(mixer_cfg.dead_zone) : int'(DEFAULT_DEAD_ZONE);
      if (s.mode == MODE_TURBO) begin
         ax = mixer_cfg.turn_stick ? $signed(s.right_x) : $signed(s.left_x);
         if (mixer_cfg.axis_invert[0]) ax = -ax;
         steer = apply_dead_zone(ax, z) * int'(mixer_cfg.turn_gain) * 20;
         steer = clamp(steer, -STEER_LIMIT, STEER_LIMIT);
         base  = int'(mixer_cfg.pwm_max) * Q13;
         d.left_forward  = 8'(clamp(clamp(base + steer, 0, 255 * Q13) / Q13
                                    + int'(mixer_cfg.trim_left), 0, 255));
         d.right_forward = 8'(clamp(clamp(base - steer, 0, 255 * Q13) / Q13
                                    + int'(mixer_cfg.trim_right), 0, 255));
      end else begin
         x = $signed(s.right_x);
         y = -int'($signed(s.right_y));
         if (mixer_cfg.axis_invert[0]) x = -x;
         if (mixer_cfg.axis_invert[1]) y = -y;
         fw = apply_dead_zone(y, z);
         tn = apply_dead_zone(x, z);
         // Both sticks idle: motors stop and the trim is not applied.
         if (fw == 0 && tn == 0) return '0;
         k = 127 * int'(mixer_cfg.speed_factor);
         drive_side((fw + tn) * k, int'(mixer_cfg.trim_left),
                    d.left_forward, d.left_reverse);
         drive_side((fw - tn) * k, int'(mixer_cfg.trim_right),
                    d.right_forward, d.right_reverse);
      end
      return d;
   endfunction

   // Directed table; typed duties hold under the reset settings only.
   function automatic directed_row_type directed_row(int i);
      case (i)
         0:  return '{'{MODE_NORMAL, 10'sd0, 10'sd0, 10'sd0}, 1'b1, '{8'd0, 8'd0, 8'd0, 8'd0}};
         1:  return '{'{MODE_TURBO, 10'sd0, 10'sd0, 10'sd0}, 1'b1,
                      '{8'd220, 8'd0, 8'd220, 8'd0}};
         2:  return '{'{MODE_TURBO, -10'sd512, 10'sd0, 10'sd0}, 1'b1,
                      '{8'd200, 8'd0, 8'd240, 8'd0}};
         3:  return '{'{MODE_TURBO, 10'sd511, -10'sd512, 10'sd511}, 1'b0, '0};
         4:  return '{'{MODE_NORMAL, 10'sd0, 10'sd0, -10'sd512}, 1'b1,
                      '{8'd127, 8'd0, 8'd127, 8'd0}};
         5:  return '{'{MODE_NORMAL, 10'sd0, 10'sd511, 10'sd0}, 1'b0, '0};
         6:  return '{'{MODE_NORMAL, 10'sd0, -10'sd512, 10'sd511}, 1'b0, '0};
         7:  return '{'{MODE_NORMAL, 10'sd0, 10'sd9, -10'sd9}, 1'b1, '0};
         8:  return '{'{MODE_NORMAL, 10'sd511, 10'sd10, 10'sd0}, 1'b1, '0};
         9:  return '{'{MODE_NORMAL, -10'sd512, -10'sd512, -10'sd512}, 1'b0, '0};
         10: return '{'{MODE_TURBO, -10'sd200, 10'sd300, -10'sd512}, 1'b0, '0};
         11: return '{'{MODE_NORMAL, 10'sd0, 10'sd511, 10'sd511}, 1'b0, '0};
         default: return '{'{MODE_TURBO, 10'sd10, 10'sd0, 10'sd0}, 1'b1,
                           '{8'd220, 8'd0, 8'd220, 8'd0}};
      endcase
   endfunction

   function automatic int pick_level(int lo, int hi);
      case ($urandom_range(3))
         0:       return lo;
         1:       return hi;
         default: return lo + int'($urandom_range(hi - lo));
      endcase
   endfunction

   function automatic mixer_cfg_type random_setting();
      mixer_cfg_type c;
      c.pwm_max      = 8'(pick_level(0, 255));
      c.trim_left    = 9'(pick_level(-255, 255));
      c.trim_right   = 9'(pick_level(-255, 255));
      c.axis_invert  = 2'($urandom_range(3));
      c.dead_zone    = 9'(pick_level(0, 100 + ($urandom_range(1) * 411)));
      c.turn_gain    = 8'(pick_level(0, 255));
      c.turn_stick   = 1'($urandom_range(1));
      c.speed_factor = 8'(pick_level(0, 255));
      return c;
   endfunction

   // Axis value: extremes, values around the dead-zone edge, or anything.
   function automatic logic signed [AXIS_W-1:0] random_axis();
      int z;
      int v;
      z = (mixer_cfg.dead_zone != 0) ? int'(mixer_cfg.dead_zone) : int'(DEFAULT_DEAD_ZONE);
      case ($urandom_range(7))
         0: v = -512;
         1: v = 511;
         2: v = 0;
         3: begin
            v = clamp(z - 1 + int'($urandom_range(2)), 0, 511);
            if ($urandom_range(1)) v = -v;
         end
         default: v = int'($urandom_range(1023)) - 512;
      endcase
      return AXIS_W'(v);
   endfunction

   function automatic stick_sample_type random_sample();
      stick_sample_type s;
      s.mode    = 1'($urandom_range(1));
      s.left_x  = random_axis();
      s.right_x = random_axis();
      s.right_y = random_axis();
      return s;
   endfunction

   // Register write; the predictor copy follows the block.
   task automatic write_register(csr_index_type idx, logic [CSR_W-1:0] value);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      @(negedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         CSR_PWM_MAX:      mixer_cfg.pwm_max      = value[7:0];
         CSR_TRIM_LEFT:    mixer_cfg.trim_left    = value;
         CSR_TRIM_RIGHT:   mixer_cfg.trim_right   = value;
         CSR_AXIS_INVERT:  mixer_cfg.axis_invert  = value[1:0];
         CSR_DEAD_ZONE:    mixer_cfg.dead_zone    = value;
         CSR_TURN_GAIN:    mixer_cfg.turn_gain    = value[7:0];
         CSR_TURN_STICK:   mixer_cfg.turn_stick   = value[0];
         CSR_SPEED_FACTOR: mixer_cfg.speed_factor = value[7:0];
         default: ;
      endcase
   endtask

   task automatic apply_setting(mixer_cfg_type c);
      write_register(CSR_PWM_MAX, 9'(c.pwm_max));
      write_register(CSR_TRIM_LEFT, c.trim_left);
      write_register(CSR_TRIM_RIGHT, c.trim_right);
      write_register(CSR_AXIS_INVERT, 9'(c.axis_invert));
      write_register(CSR_DEAD_ZONE, c.dead_zone);
      write_register(CSR_TURN_GAIN, 9'(c.turn_gain));
      write_register(CSR_TURN_STICK, 9'(c.turn_stick));
      write_register(CSR_SPEED_FACTOR, 9'(c.speed_factor));
   endtask

   // One input beat: random gap, then hold start until the block takes it.
   task automatic send_sample(stick_sample_type s, logic use_typed, duty_set_type typed);
      while (int'($urandom_range(99)) < sender_gap_pct) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start       <= 1'b1;
      req_mode    <= s.mode;
      req_left_x  <= s.left_x;
      req_right_x <= s.right_x;
      req_right_y <= s.right_y;
      do @(posedge clock); while (busy !== 1'b0);
      pending_duties.push_back(use_typed ? typed : mix_duties(s));
   endtask

   // Stop sending and let every expected beat come back.
   task automatic wait_drained();
      @(negedge clock);
      start <= 1'b0;
      while (pending_duties.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic note_mismatch(string what, duty_set_type want, duty_set_type got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("%0t %s: expected lf=%0d lr=%0d rf=%0d rr=%0d, got lf=%0d lr=%0d rf=%0d rr=%0d",
                  $realtime, what, want.left_forward, want.left_reverse, want.right_forward,
                  want.right_reverse, got.left_forward, got.left_reverse, got.right_forward,
                  got.right_reverse);
   endtask

   // Result checker: every strobed beat against the oldest expectation.
   always @(posedge clock) begin
      duty_set_type got;
      duty_set_type want;
      got = {rsp_left_forward, rsp_left_reverse, rsp_right_forward, rsp_right_reverse};
      if (!reset && rsp_strobe === 1'b1) begin
         if (pending_duties.size() == 0) begin
            note_mismatch("unexpected result beat", '0, got);
         end else begin
            want = pending_duties.pop_front();
            if (got.left_forward !== want.left_forward || got.left_reverse !== want.left_reverse
                || got.right_forward !== want.right_forward
                || got.right_reverse !== want.right_reverse)
               note_mismatch("duty mismatch", want, got);
         end
      end else if (rsp_strobe !== 1'b0 && !reset) begin
         note_mismatch("unknown result strobe", '0, got);
      end
   end

   // Main sequence: reset, directed table, then random blocks under several settings.
   initial begin
      int               gaps[3];
      directed_row_type row;
      mixer_cfg_type    alt;
      mixer_cfg_type    lows;
      mixer_cfg_type    highs;

      gaps  = '{32, 88, 0};
      alt   = '{8'd100, -9'sd30, 9'sd40, 2'd3, 9'd0, 8'd255, 1'b1, 8'd255};
      lows  = '{8'd0, -9'sd255, -9'sd255, 2'd0, 9'd0, 8'd0, 1'b0, 8'd0};
      highs = '{8'd255, 9'sd255, 9'sd255, 2'd3, 9'd511, 8'd255, 1'b1, 8'd255};
      mixer_cfg = '{RST_PWM_MAX, 9'sd0, 9'sd0, 2'd0, RST_DEAD_ZONE, RST_TURN_GAIN, 1'b0,
                    RST_SPEED_FACTOR};
      mismatch_count = 0;
      sender_gap_pct = gaps[0];

      reset        = 1'b1;
      start        = 1'b0;
      req_mode     = MODE_NORMAL;
      req_left_x   = '0;
      req_right_x  = '0;
      req_right_y  = '0;
      csr_write_en = 1'b0;
      csr_index    = CSR_PWM_MAX;
      csr_wdata    = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed table under reset settings, then again under an unusual setting.
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         row = directed_row(i);
         send_sample(row.sample, row.known, row.duties);
      end
      wait_drained();
      apply_setting(alt);
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         row = directed_row(i);
         send_sample(row.sample, 1'b0, '0);
      end
      wait_drained();

      // Random blocks for each sender gap rate.
      for (int g = 0; g < 3; g++) begin
         sender_gap_pct = gaps[g];
         for (int b = 0; b < 4; b++) begin
            case (b)
               1:       apply_setting(lows);
               2:       apply_setting(highs);
               default: apply_setting(random_setting());
            endcase
            for (int n = 0; n < ITEMS_PER_BLOCK; n++)
               send_sample(random_sample(), 1'b0, '0);
            wait_drained();
         end
      end

      if (mismatch_count == 0 && pending_duties.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/jddm_pkg.sv
rtl/core/joystick_differential_drive_mixer.sv
sim/tb_joystick_differential_drive_mixer.sv
